// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the bucket table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BOB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define BOB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- hw/rtl/bob_pkg.sv -----
// Shared constants, codes and types of the bucket block table.
package bob_pkg;

    // Built size of the bucket and its field widths.
    localparam int MAX_ENTRIES  = 8;
    localparam int PAYLOAD_BITS = 64;
    localparam int ID_W         = 32;
    localparam int PORT_PAY_W   = 64;
    localparam int OP_W         = 2;
    localparam int STAT_W       = 2;
    localparam int CAP_W        = 4;
    localparam int FILL_W       = 4;
    localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int CNTX_W       = CNT_W + 1;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Access request from the sequencer to the entry store.
    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic [ID_W-1:0]         wid;
        logic [PAYLOAD_BITS-1:0] wpayload;
        logic                    re;
        logic [IDX_W-1:0]        raddr;
    } t_mem_req;

endpackage

// ----- hw/rtl/bob_store.sv -----
// Entry store of the bucket with registered read and the shared identifier comparator.
module bob_store (
    input  logic                             i_clk,
    input  bob_pkg::t_mem_req                i_mem_req,
    input  logic [bob_pkg::ID_W-1:0]         i_key,
    output logic [bob_pkg::ID_W-1:0]         o_rd_id,
    output logic [bob_pkg::PAYLOAD_BITS-1:0] o_rd_payload,
    output logic                             o_hit
);
    import bob_pkg::*;

    logic [ID_W-1:0]         r_ids      [MAX_ENTRIES];
    logic [PAYLOAD_BITS-1:0] r_payloads [MAX_ENTRIES];
    logic [ID_W-1:0]         r_rd_id;
    logic [PAYLOAD_BITS-1:0] r_rd_payload;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_mem_req.we) begin
            r_ids[i_mem_req.waddr]      <= i_mem_req.wid;
            r_payloads[i_mem_req.waddr] <= i_mem_req.wpayload;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_mem_req.re) begin
            r_rd_id      <= r_ids[i_mem_req.raddr];
            r_rd_payload <= r_payloads[i_mem_req.raddr];
        end
    end

    // The one comparator, reused for every entry of a scan.
    assign o_hit        = (r_rd_id == i_key);
    assign o_rd_id      = r_rd_id;
    assign o_rd_payload = r_rd_payload;

endmodule

// ----- hw/rtl/bob_ctrl.sv -----
// Sequencer that scans, shifts and appends entries of the bucket one at a time.
`include "assert_macros.svh"

module bob_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [bob_pkg::OP_W-1:0]         i_opcode,
    input  logic [bob_pkg::ID_W-1:0]         i_block_id,
    input  logic [bob_pkg::PAYLOAD_BITS-1:0] i_block_payload,
    input  logic [bob_pkg::CAP_W-1:0]        i_capacity,
    input  logic [bob_pkg::ID_W-1:0]         i_rd_id,
    input  logic [bob_pkg::PAYLOAD_BITS-1:0] i_rd_payload,
    input  logic                             i_hit,
    output bob_pkg::t_mem_req                o_mem_req,
    output logic [bob_pkg::ID_W-1:0]         o_key,
    output logic                             o_busy,
    output logic                             o_strobe,
    output logic [bob_pkg::STAT_W-1:0]       o_status,
    output logic [bob_pkg::PAYLOAD_BITS-1:0] o_found_payload,
    output logic [bob_pkg::FILL_W-1:0]       o_fill_count
);
    import bob_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_READ     = 6'b000010,
        S_CMP      = 6'b000100,
        S_SHIFT_RD = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_idx, n_idx;
    t_opcode                 r_op, n_op;
    logic [ID_W-1:0]         r_id, n_id;
    t_status                 r_status, n_status;
    logic [PAYLOAD_BITS-1:0] r_found, n_found;

    logic             w_accept;
    logic             w_room;
    logic [CNT_W-1:0] w_next;
    t_mem_req         w_req;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_next   = CNT_W'(r_idx) + CNT_W'(1);
    assign w_room   = (32'(r_count) < 32'(i_capacity)) && (32'(r_count) < 32'(MAX_ENTRIES));

    // Next-state logic: each entry is read in S_READ and compared in S_CMP, or moved by S_SHIFT_RD and S_SHIFT_WR.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_op     = r_op;
        n_id     = r_id;
        n_status = r_status;
        n_found  = r_found;
        w_req    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = t_opcode'(i_opcode);
                    n_id     = i_block_id;
                    n_status = ST_DONE;
                    n_found  = '0;
                    n_idx    = '0;
                    n_state  = S_DONE;
                    unique case (t_opcode'(i_opcode)) inside
                        OP_INSERT: begin
                            if (w_room) begin
                                w_req.we       = 1'b1;
                                w_req.waddr    = IDX_W'(r_count);
                                w_req.wid      = i_block_id;
                                w_req.wpayload = i_block_payload;
                                n_count        = r_count + CNT_W'(1);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_REMOVE, OP_LOOKUP: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_idx;
                n_state     = S_CMP;
            end
            S_CMP: begin
                if (i_hit) begin
                    if (r_op == OP_LOOKUP) begin
                        n_found = i_rd_payload;
                        n_state = S_DONE;
                    end else if (w_next < r_count) begin
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_DONE;
                    end
                end else if (w_next < r_count) begin
                    n_idx   = IDX_W'(w_next);
                    n_state = S_READ;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                w_req.re    = 1'b1;
                w_req.raddr = IDX_W'(w_next);
                n_state     = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                w_req.we       = 1'b1;
                w_req.waddr    = r_idx;
                w_req.wid      = i_rd_id;
                w_req.wpayload = i_rd_payload;
                if ((CNTX_W'(w_next) + CNTX_W'(1)) < CNTX_W'(r_count)) begin
                    n_idx   = IDX_W'(w_next);
                    n_state = S_SHIFT_RD;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Transaction context and result registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_op     <= n_op;
        r_id     <= n_id;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_mem_req       = w_req;
    assign o_key           = r_id;
    assign o_busy          = (r_state != S_IDLE);
    assign o_strobe        = (r_state == S_DONE);
    assign o_status        = r_status;
    assign o_found_payload = r_found;
    assign o_fill_count    = FILL_W'(r_count);

    // The held count never passes the built entry count.
    `BOB_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, 32'(r_count) > 32'(MAX_ENTRIES), "count overflow")
    // An insert grows the count by one at most.
    `BOB_ASSERT_CLK(a_insert_step, i_clk, i_rst_n, (w_accept && (i_opcode == OP_INSERT)) |=> ((r_count == $past(r_count)) || (r_count == ($past(r_count) + CNT_W'(1)))), "insert count step")
    // The store is written only by an accepted insert or a shift.
    `BOB_ASSERT_CLK(a_write_source, i_clk, i_rst_n, w_req.we |-> ((r_state == S_SHIFT_WR) || (w_accept && (i_opcode == OP_INSERT))), "stray store write")

endmodule

// ----- hw/rtl/oram_bucket_block_table.sv -----
// Top level of the bucket block table: capacity register, sequencer and entry store.
//
// Each transaction is accepted when start is high and busy is low, and gives
// exactly one result, shown for a single cycle with o_result_strobe high; the
// receiver cannot stall it, so the result must be taken in that cycle. An
// insert, a no-op, or a lookup or remove on an empty bucket shows its result
// in the cycle right after acceptance. A lookup or a remove scans the entries
// in order through one registered read port and one identifier comparator,
// reading and then comparing each entry examined; a remove then moves each
// later entry down one place, reading it and then writing it. The block
// cannot take a new transaction while one is in progress, and a new one can
// be accepted in the cycle after the strobe. The longest case, in which the
// entries examined and the entries moved are eight in all, is for example a
// remove of the first of eight entries or a miss over eight entries. Busy is
// high from the cycle after acceptance up to and including the strobe cycle.
// The capacity register may be written only while the block is idle; no
// clearing pass is needed after reset.
module oram_bucket_block_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [bob_pkg::OP_W-1:0]         i_opcode,
    input  logic [bob_pkg::ID_W-1:0]         i_block_id,
    input  logic [bob_pkg::PORT_PAY_W-1:0]   i_block_payload,
    input  logic                             i_cfg_we,
    input  logic [bob_pkg::CAP_W-1:0]        i_cfg_wdata,
    output logic                             busy,
    output logic                             o_result_strobe,
    output logic [bob_pkg::STAT_W-1:0]       o_status,
    output logic [bob_pkg::PORT_PAY_W-1:0]   o_found_payload,
    output logic [bob_pkg::FILL_W-1:0]       o_fill_count
);
    import bob_pkg::*;

    logic [CAP_W-1:0]        r_capacity;
    t_mem_req                w_mem_req;
    logic [ID_W-1:0]         w_key;
    logic [ID_W-1:0]         w_rd_id;
    logic [PAYLOAD_BITS-1:0] w_rd_payload;
    logic                    w_hit;
    logic [PAYLOAD_BITS-1:0] w_found;

    // Capacity register, written directly from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Sequencer.
    bob_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_opcode        (i_opcode),
        .i_block_id      (i_block_id),
        .i_block_payload (PAYLOAD_BITS'(i_block_payload)),
        .i_capacity      (r_capacity),
        .i_rd_id         (w_rd_id),
        .i_rd_payload    (w_rd_payload),
        .i_hit           (w_hit),
        .o_mem_req       (w_mem_req),
        .o_key           (w_key),
        .o_busy          (busy),
        .o_strobe        (o_result_strobe),
        .o_status        (o_status),
        .o_found_payload (w_found),
        .o_fill_count    (o_fill_count)
    );

    // Entry store and comparator.
    bob_store u_store (
        .i_clk        (i_clk),
        .i_mem_req    (w_mem_req),
        .i_key        (w_key),
        .o_rd_id      (w_rd_id),
        .o_rd_payload (w_rd_payload),
        .o_hit        (w_hit)
    );

    assign o_found_payload = PORT_PAY_W'(w_found);

endmodule
